@@ rtl/core/tcfc_pkg.sv @@
// shared types and constants of the touch coordinate filter and calibration block
package tcfc_pkg;

  localparam int FILTER_DEPTH = 3;
  localparam int COORD_W      = 12;
  localparam int IDX_W        = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int SUM_W        = COORD_W + $clog2(FILTER_DEPTH);
  localparam int RECIP_SH     = SUM_W + $clog2(FILTER_DEPTH);
  localparam int RECIP_W      = RECIP_SH + 1;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + FILTER_DEPTH - 1) / FILTER_DEPTH);

  localparam logic [COORD_W-1:0] COORD_MAX      = 12'hFFF;
  localparam logic [3:0]         KEYBOARD_SHIFT = 4'd10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPLAY_WIDTH  = 3'd0,
    CFG_DISPLAY_HEIGHT = 3'd1,
    CFG_SCALE_X        = 3'd2,
    CFG_SCALE_Y        = 3'd3,
    CFG_OFFSET_X       = 3'd4,
    CFG_OFFSET_Y       = 3'd5,
    CFG_BYPASS_CAL     = 3'd6,
    CFG_KEYBOARD_SHIFT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic       report_valid;
    logic [7:0] finger_count;
    logic [7:0] x_high_byte;
    logic [7:0] x_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] y_low_byte;
  } in_t;

  typedef struct packed {
    logic               pressed;
    logic               new_press;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } out_t;

  typedef struct packed {
    logic [COORD_W-1:0]        lim_x;
    logic [COORD_W-1:0]        lim_y;
    logic [15:0]               scale_x;
    logic [15:0]               scale_y;
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
    logic                      bypass_cal;
    logic                      keyboard_shift;
  } cfg_t;

  typedef struct packed {
    logic               pressed;
    logic               new_press;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } filt_t;

endpackage

@@ rtl/core/touch_coordinate_filter_calibrate.sv @@
// top level of the touch coordinate filter and calibration block
//
// input channel: in_valid_i / in_stall_o carry one touch report per beat
// (valid flag, finger count, four coordinate bytes); output channel:
// out_valid_o / out_stall_i carry one result per report (pressed, new
// press, calibrated x and y). a beat moves when valid is high and stall low.
// config port: cfg_valid_i / cfg_ready_o with a 3-bit register index and
// 16-bit data; ready is always high, write only while the block is idle.
// pipeline: input register, filter stage (decode, clamp, 3-sample average
// through a reciprocal multiply), calibration stage (one 12x16 multiply per
// axis, offset add, saturation) into the result register. one report per
// cycle is taken while the receiver does not stall.
// when the receiver stalls the whole pipeline holds and in_stall_o rises
// in the same cycle, so nothing is lost or repeated.
// reset clears the pipeline valids, filter and touch state, and loads the
// register defaults (240 x 240 display, unity gain, zero offset).
module touch_coordinate_filter_calibrate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tcfc_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tcfc_pkg::out_t                  out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  tcfc_pkg::cfg_idx_e              cfg_index_i,
  input  logic [tcfc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tcfc_pkg::*;

  cfg_t  cfg;
  filt_t mid;
  logic  mid_valid;
  logic  adv;
  logic  in_acc;

  // pipeline moves unless a result is held by the receiver
  assign adv        = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~adv;
  assign in_acc     = in_valid_i & adv;

  tcfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tcfc_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_acc_i    (in_acc),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .mid_valid_o (mid_valid),
    .mid_o       (mid)
  );

  tcfc_calib u_calib (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .mid_valid_i (mid_valid),
    .mid_i       (mid),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_o       (out_data_o)
  );

endmodule

@@ rtl/core/tcfc_cfg_regs.sv @@
// configuration registers and derived display limits
module tcfc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  tcfc_pkg::cfg_idx_e            cfg_index_i,
  input  logic [tcfc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output tcfc_pkg::cfg_t                cfg_o
);
  import tcfc_pkg::*;

  logic [12:0]               width_q, height_q;
  logic [15:0]               scale_x_q, scale_y_q;
  logic signed [COORD_W-1:0] offset_x_q, offset_y_q;
  logic                      bypass_q, kbd_q;

  function automatic logic [COORD_W-1:0] dim_limit(input logic [12:0] dim);
    logic [12:0] m1;
    m1 = dim - 13'd1;
    if (dim == 13'd0) begin
      return '0;
    end else if (m1 > 13'(COORD_MAX)) begin
      return COORD_MAX;
    end else begin
      return m1[COORD_W-1:0];
    end
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 13'd240;
      height_q   <= 13'd240;
      scale_x_q  <= 16'd4096;
      scale_y_q  <= 16'd4096;
      offset_x_q <= '0;
      offset_y_q <= '0;
      bypass_q   <= 1'b0;
      kbd_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DISPLAY_WIDTH:  width_q    <= cfg_data_i[12:0];
        CFG_DISPLAY_HEIGHT: height_q   <= cfg_data_i[12:0];
        CFG_SCALE_X:        scale_x_q  <= cfg_data_i;
        CFG_SCALE_Y:        scale_y_q  <= cfg_data_i;
        CFG_OFFSET_X:       offset_x_q <= cfg_data_i[COORD_W-1:0];
        CFG_OFFSET_Y:       offset_y_q <= cfg_data_i[COORD_W-1:0];
        CFG_BYPASS_CAL:     bypass_q   <= cfg_data_i[0];
        CFG_KEYBOARD_SHIFT: kbd_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.lim_x          = dim_limit(width_q);
    cfg_o.lim_y          = dim_limit(height_q);
    cfg_o.scale_x        = scale_x_q;
    cfg_o.scale_y        = scale_y_q;
    cfg_o.offset_x       = offset_x_q;
    cfg_o.offset_y       = offset_y_q;
    cfg_o.bypass_cal     = bypass_q;
    cfg_o.keyboard_shift = kbd_q;
  end

endmodule

@@ rtl/core/tcfc_filter.sv @@
// input register, coordinate decode and moving average with touch state
module tcfc_filter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            in_acc_i,
  input  tcfc_pkg::in_t   in_data_i,
  input  tcfc_pkg::cfg_t  cfg_i,
  output logic            mid_valid_o,
  output tcfc_pkg::filt_t mid_o
);
  import tcfc_pkg::*;

  in_t                in_q;
  logic               in_vld_q;
  logic [COORD_W-1:0] hist_x_q [FILTER_DEPTH];
  logic [COORD_W-1:0] hist_y_q [FILTER_DEPTH];
  logic [COORD_W-1:0] hist_x_d [FILTER_DEPTH];
  logic [COORD_W-1:0] hist_y_d [FILTER_DEPTH];
  logic [IDX_W-1:0]   fill_q, fill_d;
  logic               ready_q, ready_d;
  logic               active_q, active_d;
  logic               prev_q, prev_d;
  logic [COORD_W-1:0] filt_x_q, filt_x_d, filt_y_q, filt_y_d;
  logic [COORD_W-1:0] raw_x, raw_y, dec_x, dec_y;
  logic [SUM_W-1:0]   sum_x, sum_y;
  logic [PROD_W-1:0]  avg_px, avg_py;
  logic               step;
  filt_t              mid_q, mid_d;
  logic               mid_vld_q;

  assign step  = adv_i & in_vld_q;
  assign dec_x = {in_q.x_high_byte[3:0], in_q.x_low_byte};
  assign dec_y = {in_q.y_high_byte[3:0], in_q.y_low_byte};
  assign raw_x = (dec_x > cfg_i.lim_x) ? cfg_i.lim_x : dec_x;
  assign raw_y = (dec_y > cfg_i.lim_y) ? cfg_i.lim_y : dec_y;

  always_comb begin
    hist_x_d = hist_x_q;
    hist_y_d = hist_y_q;
    fill_d   = fill_q;
    active_d = active_q;
    sum_x    = '0;
    sum_y    = '0;
    if (in_q.report_valid) begin
      if (in_q.finger_count != 8'd0) begin
        hist_x_d[fill_q] = raw_x;
        hist_y_d[fill_q] = raw_y;
        fill_d = (fill_q == IDX_W'(FILTER_DEPTH - 1)) ? '0 : fill_q + IDX_W'(1);
        active_d = 1'b1;
      end else begin
        active_d = 1'b0;
        fill_d   = '0;
      end
    end
    for (int i = 0; i < FILTER_DEPTH; i++) begin
      sum_x = sum_x + SUM_W'(hist_x_d[i]);
      sum_y = sum_y + SUM_W'(hist_y_d[i]);
    end
  end

  // divide by depth through a reciprocal multiply
  assign avg_px = PROD_W'(sum_x) * PROD_W'(RECIP);
  assign avg_py = PROD_W'(sum_y) * PROD_W'(RECIP);

  always_comb begin
    ready_d  = ready_q;
    filt_x_d = filt_x_q;
    filt_y_d = filt_y_q;
    if (in_q.report_valid) begin
      if (in_q.finger_count != 8'd0) begin
        if (!ready_q) begin
          if (fill_d == '0) begin
            ready_d = 1'b1;
          end
          filt_x_d = raw_x;
          filt_y_d = raw_y;
        end else begin
          filt_x_d = avg_px[RECIP_SH +: COORD_W];
          filt_y_d = avg_py[RECIP_SH +: COORD_W];
        end
      end else begin
        ready_d = 1'b0;
      end
    end
  end

  always_comb begin
    prev_d          = active_d;
    mid_d.pressed   = active_d;
    mid_d.new_press = active_d & ~prev_q;
    mid_d.pos_x     = filt_x_d;
    mid_d.pos_y     = filt_y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      fill_q    <= '0;
      ready_q   <= 1'b0;
      active_q  <= 1'b0;
      prev_q    <= 1'b0;
      filt_x_q  <= '0;
      filt_y_q  <= '0;
    end else begin
      if (adv_i) begin
        in_vld_q  <= in_acc_i;
        mid_vld_q <= in_vld_q;
      end
      if (step) begin
        fill_q   <= fill_d;
        ready_q  <= ready_d;
        active_q <= active_d;
        prev_q   <= prev_d;
        filt_x_q <= filt_x_d;
        filt_y_q <= filt_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && in_acc_i) begin
      in_q <= in_data_i;
    end
    if (step) begin
      hist_x_q <= hist_x_d;
      hist_y_q <= hist_y_d;
      mid_q    <= mid_d;
    end
  end

  assign mid_valid_o = mid_vld_q;
  assign mid_o       = mid_q;

endmodule

@@ rtl/core/tcfc_calib.sv @@
// gain, offset and saturation of the filtered point into the result register
module tcfc_calib (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            mid_valid_i,
  input  tcfc_pkg::filt_t mid_i,
  input  tcfc_pkg::cfg_t  cfg_i,
  output logic            out_valid_o,
  output tcfc_pkg::out_t  out_o
);
  import tcfc_pkg::*;

  out_t out_q, out_d;
  logic out_vld_q;

  function automatic logic [COORD_W-1:0] cal_axis(
    input logic [COORD_W-1:0]        pos,
    input logic [15:0]               scale,
    input logic signed [COORD_W-1:0] off,
    input logic                      bypass,
    input logic                      extra,
    input logic [COORD_W-1:0]        lim
  );
    logic [27:0]        prod;
    logic signed [12:0] add;
    logic signed [29:0] v;
    logic [17:0]        q;
    prod = bypass ? {pos, 12'h000} : 28'(pos) * 28'(scale);
    add  = (bypass ? 13'sd0 : 13'(off)) + (extra ? 13'(KEYBOARD_SHIFT) : 13'sd0);
    v    = $signed({2'b00, prod}) + $signed({{5{add[12]}}, add, 12'h000});
    q    = v[29:12];
    if (v[29]) begin
      return '0;
    end else if (q > 18'(lim)) begin
      return lim;
    end else begin
      return q[COORD_W-1:0];
    end
  endfunction

  always_comb begin
    out_d.pressed   = mid_i.pressed;
    out_d.new_press = mid_i.new_press;
    out_d.point_x   = '0;
    out_d.point_y   = '0;
    if (mid_i.pressed) begin
      out_d.point_x = cal_axis(mid_i.pos_x, cfg_i.scale_x, cfg_i.offset_x,
                               cfg_i.bypass_cal, 1'b0, cfg_i.lim_x);
      out_d.point_y = cal_axis(mid_i.pos_y, cfg_i.scale_y, cfg_i.offset_y,
                               cfg_i.bypass_cal, cfg_i.keyboard_shift, cfg_i.lim_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      out_vld_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && mid_valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule
